// ===== sv/glep_pkg.sv =====
// Shared types and constants of the gas/liquid equilibrium partition block.
// No dependencies; every module of the block imports this package.
`default_nettype none
package glep_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SAT_W     = FRAC_BITS + 1;
  localparam int CONC_W    = 32;
  localparam int KH_W      = 24;
  localparam int DSR_W     = KH_W + 2;
  localparam int PROD_W    = CONC_W + SAT_W;
  localparam int IN_W      = 88;
  localparam int OUT_W     = 72;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  localparam logic [SAT_W-1:0]  ONE_FX  = SAT_W'(1) << FRAC_BITS;
  localparam logic [KH_W-1:0]   KH_RESET = KH_W'(ONE_FX);
  localparam logic [CONC_W-1:0] CONC_MAX = '1;

  // One classified cell handed from the front to the back.
  typedef struct packed {
    logic              no_gas;
    logic [SAT_W-1:0]  sat;
    logic [SAT_W-1:0]  sg;
    logic [CONC_W-1:0] liq;
    logic [CONC_W-1:0] gas;
  } cell_t;

endpackage
`default_nettype wire

// ===== sv/glep_front.sv =====
// Front end: accepts input words, clamps the saturation and classifies the cell.
// Depends on glep_pkg.
`default_nettype none
module glep_front
  import glep_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [IN_W-1:0] in_data,
  output logic                 cell_valid,
  input  wire logic            cell_ready,
  output cell_t                cell_data
);

  logic [SAT_W-1:0] sat_raw;
  logic [SAT_W-1:0] sat_clamped;

  assign sat_raw     = in_data[SAT_W-1:0];
  assign sat_clamped = (sat_raw > ONE_FX) ? ONE_FX : sat_raw;
  assign in_ready    = !cell_valid || cell_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else if (in_ready) begin
      cell_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      cell_data.sat    <= sat_clamped;
      cell_data.sg     <= ONE_FX - sat_clamped;
      cell_data.no_gas <= (sat_clamped == ONE_FX);
      cell_data.liq    <= in_data[SAT_W +: CONC_W];
      cell_data.gas    <= in_data[SAT_W+CONC_W +: CONC_W];
    end
  end

endmodule
`default_nettype wire

// ===== sv/glep_queue.sv =====
// Short queue of classified cells between the front and the back.
// Depends on glep_pkg.
`default_nettype none
module glep_queue
  import glep_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  cell_t     wr_cell,
  output logic      rd_valid,
  input  wire logic rd_ready,
  output cell_t     rd_cell
);

  cell_t               mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                push;
  logic                pop;

  assign wr_ready = (count != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_cell  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
    if (push) mem[wr_ptr] <= wr_cell;
  end

endmodule
`default_nettype wire

// ===== sv/glep_back.sv =====
// Back end: weighted total, two pipelined restoring dividers and the output register.
// Depends on glep_pkg.
`default_nettype none
module glep_back
  import glep_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [KH_W-1:0]  kh,
  input  wire logic             cell_valid,
  output logic                  cell_ready,
  input  cell_t                 cell_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [OUT_W-1:0]      out_data
);

  typedef struct packed {
    logic              valid;
    logic              no_gas;
    logic              neg;
    logic              ovf;
    logic [SAT_W-1:0]  sat;
    logic [SAT_W-1:0]  sg;
    logic [CONC_W-1:0] total;
    logic [CONC_W-1:0] liq;
    logic [DSR_W-1:0]  dsr;
    logic [DSR_W-1:0]  rem;
    logic [CONC_W-1:0] low;
    logic [CONC_W-1:0] quo;
  } div_t;

  // One quotient bit per stage; a remainder starting below the divisor stays below it.
  function automatic div_t div_step(div_t d);
    logic [DSR_W-1:0] r2;
    div_t o;
    o     = d;
    r2    = {d.rem[DSR_W-2:0], d.low[CONC_W-1]};
    o.low = {d.low[CONC_W-2:0], 1'b0};
    if (r2 >= d.dsr) begin
      o.rem = r2 - d.dsr;
      o.quo = {d.quo[CONC_W-2:0], 1'b1};
    end else begin
      o.rem = r2;
      o.quo = {d.quo[CONC_W-2:0], 1'b0};
    end
    return o;
  endfunction

  logic                 adv;
  logic                 s0_valid, s1_valid;
  logic                 s0_no_gas, s1_no_gas;
  logic [SAT_W-1:0]     s0_sat, s1_sat, s0_sg, s1_sg;
  logic [PROD_W-1:0]    s0_pl, s0_pg;
  logic [CONC_W-1:0]    s1_total;
  logic [PROD_W:0]      sum0;
  logic [CONC_W+KH_W-1:0] prod_kh;
  div_t                 d1_init;
  div_t                 d1 [CONC_W];
  div_t                 mid_next;
  div_t                 mid;
  logic [PROD_W-1:0]    mid_part;
  logic [CONC_W+FRAC_BITS-1:0] mid_num;
  logic [CONC_W+FRAC_BITS-1:0] diff;
  div_t                 d2_init;
  div_t                 d2 [CONC_W];
  div_t                 last;
  logic [CONC_W-1:0]    liq_out, gas_out;
  logic                 flag_out;

  assign adv        = !out_valid || out_ready;
  assign cell_ready = adv;

  assign sum0    = {1'b0, s0_pl} + {1'b0, s0_pg};
  assign prod_kh = s1_total * kh;

  always_comb begin
    d1_init        = '0;
    d1_init.valid  = s1_valid;
    d1_init.no_gas = s1_no_gas;
    d1_init.sat    = s1_sat;
    d1_init.sg     = s1_sg;
    d1_init.total  = s1_total;
    d1_init.dsr    = DSR_W'(kh) + DSR_W'(s1_sg);
    d1_init.rem    = DSR_W'(prod_kh[CONC_W+KH_W-1:CONC_W]);
    d1_init.low    = prod_kh[CONC_W-1:0];
  end

  // The first quotient is the new liquid concentration.
  always_comb begin
    mid_next     = d1[CONC_W-1];
    mid_next.liq = d1[CONC_W-1].quo;
  end

  assign diff = mid_num - mid_part[CONC_W+FRAC_BITS-1:0];

  // The gas quotient overflows 32 bits when the upper part of the numerator
  // already reaches the divisor.
  always_comb begin
    d2_init     = mid;
    d2_init.neg = (mid_part > PROD_W'(mid_num));
    d2_init.ovf = (SAT_W'(diff[CONC_W+FRAC_BITS-1:CONC_W]) >= mid.sg);
    d2_init.dsr = DSR_W'(mid.sg);
    d2_init.rem = DSR_W'(diff[CONC_W+FRAC_BITS-1:CONC_W]);
    d2_init.low = diff[CONC_W-1:0];
    d2_init.quo = '0;
  end

  always_comb begin
    last = d2[CONC_W-1];
    if (last.no_gas) begin
      liq_out  = last.total;
      gas_out  = '0;
      flag_out = 1'b0;
    end else if (last.neg) begin
      liq_out  = last.liq;
      gas_out  = '0;
      flag_out = 1'b1;
    end else if (last.ovf) begin
      liq_out  = last.liq;
      gas_out  = CONC_MAX;
      flag_out = 1'b1;
    end else begin
      liq_out  = last.liq;
      gas_out  = last.quo;
      flag_out = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      mid.valid <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < CONC_W; i++) begin
        d1[i].valid <= 1'b0;
        d2[i].valid <= 1'b0;
      end
    end else if (adv) begin
      s0_valid  <= cell_valid;
      s1_valid  <= s0_valid;
      d1[0]     <= div_step(d1_init);
      d2[0]     <= div_step(d2_init);
      for (int i = 1; i < CONC_W; i++) begin
        d1[i] <= div_step(d1[i-1]);
        d2[i] <= div_step(d2[i-1]);
      end
      mid       <= mid_next;
      out_valid <= last.valid;
    end
    if (adv) begin
      s0_no_gas <= cell_data.no_gas;
      s0_sat    <= cell_data.sat;
      s0_sg     <= cell_data.sg;
      s0_pl     <= cell_data.liq * cell_data.sat;
      s0_pg     <= cell_data.gas * cell_data.sg;
      s1_no_gas <= s0_no_gas;
      s1_sat    <= s0_sat;
      s1_sg     <= s0_sg;
      s1_total  <= sum0[CONC_W+FRAC_BITS-1:FRAC_BITS];
      mid_part  <= d1[CONC_W-1].sat * d1[CONC_W-1].quo;
      mid_num   <= {d1[CONC_W-1].total, FRAC_BITS'(0)};
      out_data  <= {7'b0, flag_out, gas_out, liq_out};
    end
  end

endmodule
`default_nettype wire

// ===== sv/gas_liquid_equilibrium_partition_core.sv =====
// Top level of the gas/liquid equilibrium partition block.
// Depends on glep_pkg, glep_front, glep_queue and glep_back.
//
// Each input word carries one grid cell: liquid saturation (Q1.16, values
// above one are clamped to one) and the liquid and gas concentrations of one
// species (Q16.16). The block forms the saturation-weighted total and splits
// it again with the partition coefficient kH from the configuration port.
// One output word leaves for every input word, in order.
// The front registers and classifies each word, a four-entry queue decouples
// it from the back, and the back is a stall-together pipeline of 68 stages:
// a multiply stage, an add stage, a 32-stage restoring divider for the liquid
// part, one multiply stage, a second 32-stage divider for the gas part and the
// output register. Throughput is one cell per cycle while the output is not
// stalled, since every stage takes a new cell each cycle. When the receiver
// holds m_axis_tready low the back freezes, the queue fills and then
// s_axis_tready falls; nothing is lost. Synchronous reset empties all stages
// and sets kH to one. The coefficient is written through cfg_valid/cfg_data
// (always ready) by the user only while the block is idle; it is not enforced.
`default_nettype none
module gas_liquid_equilibrium_partition_core
  import glep_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // [16:0] liquid_saturation, [48:17] liquid_concentration,
  // [80:49] gas_concentration, rest zero
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // [31:0] new_liquid_concentration, [63:32] new_gas_concentration,
  // [64] saturated, rest zero
  output logic [OUT_W-1:0]      m_axis_tdata,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [KH_W-1:0]  cfg_data
);

  logic [KH_W-1:0] kh;
  logic            f_valid, f_ready, q_valid, q_ready;
  cell_t           f_cell, q_cell;

  assign cfg_ready = 1'b1;

  // The partition coefficient register.
  always_ff @(posedge clk) begin
    if (rst) begin
      kh <= KH_RESET;
    end else if (cfg_valid) begin
      kh <= cfg_data;
    end
  end

  glep_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_data    (s_axis_tdata),
    .cell_valid (f_valid),
    .cell_ready (f_ready),
    .cell_data  (f_cell)
  );

  glep_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_cell  (f_cell),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cell  (q_cell)
  );

  glep_back u_back (
    .clk        (clk),
    .rst        (rst),
    .kh         (kh),
    .cell_valid (q_valid),
    .cell_ready (q_ready),
    .cell_data  (q_cell),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata)
  );

endmodule
`default_nettype wire
